>>> rtl/pcbd_pkg.sv
package pcbd_pkg;

   localparam int STEPS_DEFAULT = 16;

   localparam int LEVEL_W    = 8;
   localparam int DURATION_W = 16;
   localparam int HALF_W     = 8;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [DURATION_W-1:0] RESET_LOW_DEFAULT  = 16'd4000;
   localparam logic [DURATION_W-1:0] START_HIGH_DEFAULT = 16'd40;
   localparam logic [HALF_W-1:0]     PULSE_HALF_DEFAULT = 8'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RESET_LOW  = 2'd0,
      CSR_START_HIGH = 2'd1,
      CSR_PULSE_HALF = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DURATION_W-1:0] reset_low_us;
      logic [DURATION_W-1:0] start_high_us;
      logic [HALF_W-1:0]     pulse_half_us;
   } cfg_type;

endpackage

>>> rtl/pcbd_if.sv
interface pcbd_req_if;
   logic                         valid;
   logic                         ready;
   logic [pcbd_pkg::LEVEL_W-1:0] brightness_level;

   modport source (output valid, output brightness_level, input ready);
   modport sink   (input valid, input brightness_level, output ready);
endinterface

interface pcbd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            pin_level;
   logic [pcbd_pkg::DURATION_W-1:0] duration_us;
   logic                            last;

   modport source (output valid, output pin_level, output duration_us, output last,
                   input ready);
   modport sink   (input valid, input pin_level, input duration_us, input last,
                   output ready);
endinterface

>>> rtl/pulse_count_backlight_dimmer_top.sv
// Sequence: a transaction is accepted in the idle state, the step is worked out in
//   the calc state, and the first segment is registered on rsp once its slot is free.
// Throughput: one segment per cycle while rsp is ready; req is not taken again until
//   the sequencer has registered the last segment of the request.
// Reset: synchronous, active high; previous step goes to 0, registers to 4000/40/1.
module pulse_count_backlight_dimmer_top #(
   parameter int STEPS = pcbd_pkg::STEPS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   pcbd_req_if.sink                        req_if,
   pcbd_rsp_if.source                      rsp_if,
   input  logic                            csr_we,
   input  logic [pcbd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcbd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pcbd_pkg::*;

   // Live registers; user must write only while no request is in flight; unenforced.
   cfg_type cfg;

   pcbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sequencer, up move: reset-low, start-high, STEPS-bounded pulse pairs, final hold.
   // req ready only in its idle state; a registered rsp slot decouples the sink.
   pcbd_seq #(
      .STEPS (STEPS)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule

>>> rtl/pcbd_csr.sv
module pcbd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [pcbd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pcbd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output pcbd_pkg::cfg_type              cfg
);
   import pcbd_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_us  <= RESET_LOW_DEFAULT;
         cfg_ff.start_high_us <= START_HIGH_DEFAULT;
         cfg_ff.pulse_half_us <= PULSE_HALF_DEFAULT;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_RESET_LOW:  cfg_ff.reset_low_us  <= csr_wdata;
            CSR_START_HIGH: cfg_ff.start_high_us <= csr_wdata;
            CSR_PULSE_HALF: cfg_ff.pulse_half_us <= csr_wdata[HALF_W-1:0];
            default: ;  // no register here
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/pcbd_seq.sv
module pcbd_seq #(
   parameter int STEPS = pcbd_pkg::STEPS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  pcbd_pkg::cfg_type cfg,
   pcbd_req_if.sink          req_if,
   pcbd_rsp_if.source        rsp_if
);
   import pcbd_pkg::*;

   localparam int STEP_W = $clog2(STEPS);
   localparam int PROD_W = LEVEL_W + STEP_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_RESET_LOW,
      ST_START_HIGH,
      ST_PULSE_HI,
      ST_PULSE_LO,
      ST_FINAL
   } state_type;

   state_type             state_ff;
   logic [LEVEL_W-1:0]    level_ff;
   logic [STEP_W-1:0]     prev_step_ff;
   logic [STEP_W-1:0]     pulses_ff;
   logic                  shutdown_ff;
   logic                  rsp_valid_ff;
   logic                  pin_ff;
   logic [DURATION_W-1:0] duration_ff;
   logic                  last_ff;

   logic [PROD_W-1:0]     prod;
   logic [STEP_W-1:0]     step_in;
   logic [DURATION_W-1:0] half;
   logic                  slot_free;

   // step = (level * STEPS) >> 8
   assign prod      = PROD_W'(level_ff) * PROD_W'(STEPS);
   assign step_in   = prod[PROD_W-1:LEVEL_W];
   assign half      = (cfg.pulse_half_us == '0) ? DURATION_W'(1)
                                                : DURATION_W'(cfg.pulse_half_us);
   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  level_ff <= req_if.brightness_level;
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               prev_step_ff <= step_in;
               shutdown_ff  <= (step_in == '0);
               if (step_in < prev_step_ff) begin
                  pulses_ff <= prev_step_ff - step_in;
               end else begin
                  pulses_ff <= STEP_W'(STEPS - int'(step_in));
               end
               if (step_in == prev_step_ff) begin
                  state_ff <= ST_IDLE;
               end else if (step_in == '0 || step_in > prev_step_ff) begin
                  state_ff <= ST_RESET_LOW;
               end else begin
                  state_ff <= ST_START_HIGH;
               end
            end
            ST_RESET_LOW: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  pin_ff       <= 1'b0;
                  duration_ff  <= cfg.reset_low_us;
                  last_ff      <= shutdown_ff;
                  state_ff     <= shutdown_ff ? ST_IDLE : ST_START_HIGH;
               end
            end
            ST_START_HIGH: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  pin_ff       <= 1'b1;
                  duration_ff  <= cfg.start_high_us;
                  last_ff      <= 1'b0;
                  state_ff     <= (pulses_ff == '0) ? ST_FINAL : ST_PULSE_HI;
               end
            end
            ST_PULSE_HI: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  pin_ff       <= 1'b1;
                  duration_ff  <= half;
                  last_ff      <= 1'b0;
                  state_ff     <= ST_PULSE_LO;
               end
            end
            ST_PULSE_LO: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  pin_ff       <= 1'b0;
                  duration_ff  <= half;
                  last_ff      <= 1'b0;
                  pulses_ff    <= pulses_ff - 1'b1;
                  state_ff     <= (pulses_ff == STEP_W'(1)) ? ST_FINAL : ST_PULSE_HI;
               end
            end
            ST_FINAL: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  pin_ff       <= 1'b1;
                  duration_ff  <= '0;
                  last_ff      <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.pin_level   = pin_ff;
   assign rsp_if.duration_us = duration_ff;
   assign rsp_if.last        = last_ff;

endmodule

>>> dv/pcbd_segment_checker.sv
`timescale 1ns / 100ps

module pcbd_segment_checker #(
   parameter int STEPS = pcbd_pkg::STEPS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   pcbd_req_if                             req_mon,
   pcbd_rsp_if                             rsp_mon,
   input  logic                            csr_we,
   input  logic [pcbd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcbd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatches,
   output int                              pending,
   output int                              segments
);
   import pcbd_pkg::*;

   typedef struct packed {
      logic                  pin_level;
      logic [DURATION_W-1:0] duration_us;
      logic                  last;
   } segment_type;

   segment_type           expected_segments[$];
   logic [DURATION_W-1:0] low_hold_us   = RESET_LOW_DEFAULT;
   logic [DURATION_W-1:0] start_hold_us = START_HIGH_DEFAULT;
   logic [HALF_W-1:0]     half_us       = PULSE_HALF_DEFAULT;
   int                    driver_step   = 0;
   int                    mismatch_cnt  = 0;
   int                    segment_cnt   = 0;
   int                    pending_cnt   = 0;

   assign mismatches = mismatch_cnt;
   assign pending    = pending_cnt;
   assign segments   = segment_cnt;

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch at segment %0d: %s", $time, segment_cnt, msg);
      mismatch_cnt++;
   endtask

   function automatic void push_segment(input logic pin, input logic [DURATION_W-1:0] dur,
                                        input logic fin);
      segment_type s;
      s.pin_level   = pin;
      s.duration_us = dur;
      s.last        = fin;
      expected_segments.push_back(s);
   endfunction

   // each pulse is a high half then a low half; a zero half length counts as one
   function automatic void push_pulses(input int count);
      logic [HALF_W-1:0] h;
      h = (half_us == '0) ? HALF_W'(1) : half_us;
      for (int i = 0; i < count; i++) begin
         push_segment(1'b1, DURATION_W'(h), 1'b0);
         push_segment(1'b0, DURATION_W'(h), 1'b0);
      end
   endfunction

   function automatic void plan_segments(input logic [LEVEL_W-1:0] level);
      int step;
      step = (int'(level) * STEPS) >> LEVEL_W;
      if (step == driver_step) return;
      if (step == 0) begin
         push_segment(1'b0, low_hold_us, 1'b1);
      end else if (step < driver_step) begin
         push_segment(1'b1, start_hold_us, 1'b0);
         push_pulses(driver_step - step);
         push_segment(1'b1, '0, 1'b1);
      end else begin
         push_segment(1'b0, low_hold_us, 1'b0);
         push_segment(1'b1, start_hold_us, 1'b0);
         push_pulses(STEPS - step);
         push_segment(1'b1, '0, 1'b1);
      end
      driver_step = step;
   endfunction

   always @(posedge clock) begin
      segment_type got;
      segment_type want;
      if (reset) begin
         low_hold_us   = RESET_LOW_DEFAULT;
         start_hold_us = START_HIGH_DEFAULT;
         half_us       = PULSE_HALF_DEFAULT;
         driver_step   = 0;
         expected_segments.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.pin_level   = rsp_mon.pin_level;
            got.duration_us = rsp_mon.duration_us;
            got.last        = rsp_mon.last;
            if (expected_segments.size() == 0) begin
               report_mismatch($sformatf("pin %0d len %0d last %0d with nothing expected",
                                         got.pin_level, got.duration_us, got.last));
            end else begin
               want = expected_segments.pop_front();
               if (got.pin_level !== want.pin_level)
                  report_mismatch($sformatf("pin_level got %0d want %0d",
                                            got.pin_level, want.pin_level));
               if (got.duration_us !== want.duration_us)
                  report_mismatch($sformatf("duration_us got %0d want %0d",
                                            got.duration_us, want.duration_us));
               if (got.last !== want.last)
                  report_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
            end
            segment_cnt++;
         end
         if (req_mon.valid && req_mon.ready)
            plan_segments(req_mon.brightness_level);
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_RESET_LOW:  low_hold_us   = csr_wdata;
               CSR_START_HIGH: start_hold_us = csr_wdata;
               CSR_PULSE_HALF: half_us       = csr_wdata[HALF_W-1:0];
               default: ;
            endcase
         end
      end
      pending_cnt <= expected_segments.size();
   end

endmodule

>>> dv/pulse_count_backlight_dimmer_top_tb.sv
`timescale 1ns / 100ps

module pulse_count_backlight_dimmer_top_tb;
   import pcbd_pkg::*;

   localparam int STEPS          = STEPS_DEFAULT;
   localparam int LIMIT_CYCLES   = 500000;
   // settle time: the longest run of a request inside the block, plus margin
   localparam int DRAIN_CYCLES   = 2 * STEPS + 8;
   localparam int LONG_HOLD      = 600;
   localparam int RANDOM_PHASES  = 6;
   localparam int MOVES_PER_PHASE = 25;

   // directed levels, default registers: equal step from reset, up to the top step,
   // equal step, down by many pulses, equal step, up again, shut off, equal step, the
   // longest train (step 1 from 0), then mid-range moves both ways
   localparam logic [LEVEL_W-1:0] DIRECTED_DEFAULT [13] =
      '{8'd0, 8'd255, 8'd240, 8'd16, 8'd31, 8'd255, 8'd0, 8'd15, 8'd16,
        8'd128, 8'd127, 8'd64, 8'd200};
   // all registers zero: zero-length holds inside a request, zero half length
   localparam logic [LEVEL_W-1:0] DIRECTED_ZERO [3] = '{8'd255, 8'd32, 8'd0};
   // all registers at their maximum
   localparam logic [LEVEL_W-1:0] DIRECTED_MAX [4] = '{8'd17, 8'd254, 8'd1, 8'd0};

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic [LEVEL_W-1:0]    req_level = '0;
   logic                  rsp_ready = 1'b0;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // idle rates in percent of cycles
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   // long output stall, armed by the stimulus and timed by the receiver
   logic long_hold_arm  = 1'b0;
   logic long_hold_done = 1'b0;
   int   hold_left      = 0;

   // what the stimulus believes the driver step is, to count step changes
   int last_step    = 0;
   int req_count    = 0;
   int move_count   = 0;
   int csr_settings = 0;
   int cycle_count  = 0;

   int mismatches;
   int pending;
   int segments;

   pcbd_req_if req_ch ();
   pcbd_rsp_if rsp_ch ();

   assign req_ch.valid            = req_valid;
   assign req_ch.brightness_level = req_level;
   assign rsp_ch.ready            = rsp_ready;

   pulse_count_backlight_dimmer_top #(.STEPS(STEPS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pcbd_segment_checker #(.STEPS(STEPS)) segment_chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending),
      .segments   (segments)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d segments still expected", cycle_count,
                  pending);
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: random ready, except during the one long stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (long_hold_arm && !long_hold_done) begin
         rsp_ready      <= 1'b0;
         hold_left      <= LONG_HOLD;
         long_hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic set_idle(input int req_pct, input int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct <= rsp_pct;
   endtask

   // offers one transaction; valid stays high into the next call unless a gap is drawn
   task automatic send_level(input logic [LEVEL_W-1:0] level);
      int step;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_level <= level;
      do @(posedge clock); while (!req_ch.ready);
      step = (int'(level) * STEPS) >> LEVEL_W;
      if (step != last_step) move_count++;
      last_step = step;
      req_count++;
   endtask

   // sender stops until every expected segment has come, then lets the block settle
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // called only while the block is idle; the unused index must be ignored
   task automatic set_registers(input logic [CSR_DATA_W-1:0] low_us,
                                input logic [CSR_DATA_W-1:0] start_us,
                                input logic [CSR_DATA_W-1:0] half_us);
      write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
      write_csr(CSR_RESET_LOW, low_us);
      write_csr(CSR_START_HIGH, start_us);
      write_csr(CSR_PULSE_HALF, half_us);
      csr_we <= 1'b0;
      csr_settings++;
   endtask

   // mostly step changes with random content, some repeats of the current step,
   // some shut-offs and some top-step requests
   function automatic logic [LEVEL_W-1:0] pick_level();
      int span;
      int r;
      span = (1 << LEVEL_W) / STEPS;
      r    = $urandom_range(99);
      if (r < 12) return LEVEL_W'(last_step * span + $urandom_range(span - 1));
      if (r < 22) return LEVEL_W'($urandom_range(span - 1));
      if (r < 30) return LEVEL_W'((STEPS - 1) * span + $urandom_range(span - 1));
      return LEVEL_W'($urandom_range((1 << LEVEL_W) - 1));
   endfunction

   // runs until the driver step has moved the given number of times; halfway the
   // sender waits for all expected segments
   task automatic run_random_phase(input int moves);
      int start_moves;
      logic paused;
      start_moves = move_count;
      paused      = 1'b0;
      while (move_count - start_moves < moves) begin
         send_level(pick_level());
         if (!paused && (move_count - start_moves >= moves / 2)) begin
            pause_until_drained();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part, sender idles 32%, receiver 86%
      set_idle(32, 86);
      foreach (DIRECTED_DEFAULT[i]) send_level(DIRECTED_DEFAULT[i]);
      pause_until_drained();
      set_registers('0, '0, '0);
      foreach (DIRECTED_ZERO[i]) send_level(DIRECTED_ZERO[i]);
      pause_until_drained();
      set_registers('1, '1, '1);
      foreach (DIRECTED_MAX[i]) send_level(DIRECTED_MAX[i]);
      pause_until_drained();

      // random part: two phases per idle profile, new registers each phase
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p / 2)
            0:       set_idle(32, 86);
            1:       set_idle(86, 32);
            default: set_idle(0, 0);
         endcase
         case (p)
            1:       set_registers('1, '1, '1);
            2:       set_registers('0, '0, '0);
            4:       set_registers(RESET_LOW_DEFAULT, START_HIGH_DEFAULT,
                                   CSR_DATA_W'(PULSE_HALF_DEFAULT));
            default: set_registers(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                                   CSR_DATA_W'($urandom));
         endcase
         // with a fast sender and no idling, stall the output long enough
         // that the block backs up into its input
         if (p == 4) long_hold_arm <= 1'b1;
         run_random_phase(MOVES_PER_PHASE);
         pause_until_drained();
      end

      $display("covered %0d requests (%0d step changes), %0d segments checked", req_count,
               move_count, segments);
      $display("over %0d register settings, three idle profiles and a %0d-cycle output stall",
               csr_settings + 1, LONG_HOLD);
      if (mismatches == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
